// File: design/assert_macros.svh
// concurrent assertion helpers, clocked on clk
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define SFR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/sfr_pkg.sv
package sfr_pkg;

  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 32;
  localparam int SUM_W     = 16;
  localparam int CNT_W     = 5;
  localparam int STORE_LEN = 24;
  localparam int NUM_WORDS = STORE_LEN / 4;

  // header characters 'i', 't', 's'
  localparam logic [BYTE_W-1:0] HDR_I = 8'h69;
  localparam logic [BYTE_W-1:0] HDR_T = 8'h74;
  localparam logic [BYTE_W-1:0] HDR_S = 8'h73;

  // body positions counted from the first byte after the header
  localparam logic [CNT_W-1:0] POS_STORE_END = 5'd24;
  localparam logic [CNT_W-1:0] POS_CSUM_LO   = 5'd27;
  localparam logic [CNT_W-1:0] POS_LAST      = 5'd28;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_T    = 4'b0010,
    PH_S    = 4'b0100,
    PH_BODY = 4'b1000
  } phase_t;

endpackage

// File: design/sfr_byte_if.sv
interface sfr_byte_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: design/sfr_pose_if.sv
interface sfr_pose_if;
  logic                       valid;
  logic                       ready;
  logic [sfr_pkg::WORD_W-1:0] global_x;
  logic [sfr_pkg::WORD_W-1:0] global_y;
  logic [sfr_pkg::WORD_W-1:0] global_heading;
  logic [sfr_pkg::WORD_W-1:0] local_x;
  logic [sfr_pkg::WORD_W-1:0] local_y;
  logic [sfr_pkg::WORD_W-1:0] sender_stamp;
  logic                       checksum_ok;

  modport source (
    output valid, output global_x, output global_y, output global_heading,
    output local_x, output local_y, output sender_stamp, output checksum_ok,
    input ready
  );
  modport sink (
    input valid, input global_x, input global_y, input global_heading,
    input local_x, input local_y, input sender_stamp, input checksum_ok,
    output ready
  );
endinterface

// File: design/serial_frame_receiver_checksum_top.sv
// serial frame receiver with inverted additive checksum
// in_ch carries one received byte per beat (rx_byte); out_ch carries one
// decoded frame per beat: five raw 32-bit pose words, a 32-bit sender stamp
// (all little-endian) and checksum_ok
// frame format: 'i' 't' 's', 24 data bytes, 3 more summed bytes, then the
// checksum low and high bytes; the checksum must equal the inverted 16-bit
// sum of frame bytes 3 to 29
// a wrong header byte drops back to hunting and is not retried as a new 'i'
// bad frames are not dropped: they come out with checksum_ok low
// throughput: one byte per cycle while out_ch does not stall, as the
// compare/add/store step for a byte is made as it leaves the input register
// the frame beat is valid on out_ch right after the edge that takes the last
// byte from the input register into the result register, which waits while
// a full result register is stalled; it can be taken at the next edge
// a stalled out_ch holds the frame; in_ch keeps taking bytes until the input
// register holds a byte that would complete another frame
// reset (rst_n low, synchronous) empties both registers and returns to
// hunting for 'i'; no clearing pass is needed
`include "assert_macros.svh"

module serial_frame_receiver_checksum_top (
  input  logic       clk,
  input  logic       rst_n,
  sfr_byte_if.sink   in_ch,
  sfr_pose_if.source out_ch
);

  // input register
  logic                       in_v_r;
  logic [sfr_pkg::BYTE_W-1:0] in_byte_r;

  // frame state
  sfr_pkg::phase_t            phase_r, phase_nxt;
  logic [sfr_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [sfr_pkg::SUM_W-1:0]  sum_r, sum_nxt;
  logic [sfr_pkg::BYTE_W-1:0] store_r [sfr_pkg::STORE_LEN];
  logic [sfr_pkg::BYTE_W-1:0] csum_lo_r;

  // result register
  logic                       out_v_r;
  logic [sfr_pkg::WORD_W-1:0] out_word_r [sfr_pkg::NUM_WORDS];
  logic                       out_ok_r;

  logic                       emit;       // byte in the input register ends a frame
  logic                       step;       // input register is consumed this cycle
  logic                       out_free;
  logic                       csum_ok;
  logic [sfr_pkg::SUM_W-1:0]  csum_rx;

  assign emit     = (phase_r == sfr_pkg::PH_BODY) && (cnt_r == sfr_pkg::POS_LAST);
  assign out_free = !out_v_r || out_ch.ready;
  assign step     = in_v_r && (!emit || out_free);
  assign in_ch.ready = !in_v_r || step;

  assign csum_rx = {in_byte_r, csum_lo_r};
  assign csum_ok = (csum_rx == ~sum_r);

  // header hunt and body bookkeeping for the byte in the input register
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    case (phase_r)
      sfr_pkg::PH_HUNT: begin
        phase_nxt = (in_byte_r == sfr_pkg::HDR_I) ? sfr_pkg::PH_T : sfr_pkg::PH_HUNT;
      end
      sfr_pkg::PH_T: begin
        phase_nxt = (in_byte_r == sfr_pkg::HDR_T) ? sfr_pkg::PH_S : sfr_pkg::PH_HUNT;
      end
      sfr_pkg::PH_S: begin
        phase_nxt = (in_byte_r == sfr_pkg::HDR_S) ? sfr_pkg::PH_BODY : sfr_pkg::PH_HUNT;
        cnt_nxt   = '0;
        sum_nxt   = '0;
      end
      sfr_pkg::PH_BODY: begin
        if (cnt_r < sfr_pkg::POS_CSUM_LO) begin
          sum_nxt = sum_r + {{(sfr_pkg::SUM_W-sfr_pkg::BYTE_W){1'b0}}, in_byte_r};
        end
        if (cnt_r == sfr_pkg::POS_LAST) begin
          phase_nxt = sfr_pkg::PH_HUNT;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        phase_nxt = sfr_pkg::PH_HUNT;
        cnt_nxt   = '0;
        sum_nxt   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      phase_r <= sfr_pkg::PH_HUNT;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (step) begin
        phase_r <= phase_nxt;
        cnt_r   <= cnt_nxt;
        sum_r   <= sum_nxt;
      end
      if (step && emit) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_byte_r <= in_ch.rx_byte;
    end
    if (step && (phase_r == sfr_pkg::PH_BODY)) begin
      if (cnt_r < sfr_pkg::POS_STORE_END) begin
        store_r[cnt_r] <= in_byte_r;
      end
      if (cnt_r == sfr_pkg::POS_CSUM_LO) begin
        csum_lo_r <= in_byte_r;
      end
    end
    if (step && emit) begin
      for (int j = 0; j < sfr_pkg::NUM_WORDS; j++) begin
        out_word_r[j] <= {store_r[4*j+3], store_r[4*j+2], store_r[4*j+1], store_r[4*j]};
      end
      out_ok_r <= csum_ok;
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.global_x       = out_word_r[0];
  assign out_ch.global_y       = out_word_r[1];
  assign out_ch.global_heading = out_word_r[2];
  assign out_ch.local_x        = out_word_r[3];
  assign out_ch.local_y        = out_word_r[4];
  assign out_ch.sender_stamp   = out_word_r[5];
  assign out_ch.checksum_ok    = out_ok_r;

  // body counter never runs past the last checksum byte
  `SFR_ASSERT(a_cnt_range, (cnt_r <= sfr_pkg::POS_LAST), "body count out of range")
  // outside the body the count and sum sit at zero
  `SFR_ASSERT(a_idle_clear, (phase_r != sfr_pkg::PH_BODY) |-> (cnt_r == '0 && sum_r == '0),
              "count or sum not cleared outside body")
  // a completed frame lands in the result register
  `SFR_ASSERT(a_emit_out, (step && emit) |=> out_v_r, "frame end did not raise out valid")
  // the input register only waits on a full, stalled result register
  `SFR_ASSERT(a_stall_cause, (in_v_r && !step) |-> (emit && out_v_r && !out_ch.ready),
              "input stalled without output backpressure")

endmodule
